// ===== hdl/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants for the dryer cycle controller
// ----------------------------------------------------------------------------
package dcc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_STOP = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KEY_NONE = 3'd0,
    KEY_LOW  = 3'd1,
    KEY_MED  = 3'd2,
    KEY_HIGH = 3'd3,
    KEY_FUNC = 3'd4
  } key_e;

  localparam logic [2:0] PG_INIT  = 3'd0;
  localparam logic [2:0] PG_DOOR  = 3'd1;
  localparam logic [2:0] PG_COIL  = 3'd5;
  localparam logic [2:0] PG_LIMIT = 3'd6;
  localparam logic [2:0] PG_DONE  = 3'd7;

  localparam logic [2:0] REG_TEMP_LOW  = 3'd0;
  localparam logic [2:0] REG_TEMP_MED  = 3'd1;
  localparam logic [2:0] REG_TEMP_HIGH = 3'd2;
  localparam logic [2:0] REG_HEAT_LOW  = 3'd3;
  localparam logic [2:0] REG_HEAT_MED  = 3'd4;
  localparam logic [2:0] REG_HEAT_HIGH = 3'd5;
  localparam logic [2:0] REG_COOL      = 3'd6;
  localparam logic [2:0] REG_LIMIT     = 3'd7;

  localparam int IN_W  = 24;
  localparam int OUT_W = 32;

  typedef struct packed {
    logic [6:0]  temp_low;
    logic [6:0]  temp_med;
    logic [6:0]  temp_high;
    logic [11:0] heat_low;
    logic [11:0] heat_med;
    logic [11:0] heat_high;
    logic [9:0]  cool_start;
    logic [4:0]  limit_reload;
  } cfg_t;

  typedef struct packed {
    logic              tick;
    logic [2:0]        key;
    logic              door_level;
    logic              door_edge;
    logic              coil_broken;
    logic              limit_open;
    logic              one_way;
    logic signed [10:0] temp;
  } scan_t;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  level;
    logic        cooling;
    logic [11:0] heat;
    logic [9:0]  cool;
    logic [4:0]  beep;
    logic [6:0]  setpoint;
    logic [1:0]  pause;
    logic [4:0]  left;
    logic [4:0]  right;
    logic        went_left;
    logic [4:0]  limit;
    logic        f_door;
    logic        f_coil;
    logic        f_limit;
    logic        running;
    logic        pending;
    logic [4:0]  drive;   // buzz, heat, right, left, fan
    logic [2:0]  page;
  } st_t;

  // idle, drum starts on a left run, limit timer at its default reload
  localparam st_t ST_RESET = '{phase: PH_IDLE, left: 5'd30, limit: 5'd30, default: '0};

  localparam int D_FAN = 0, D_LEFT = 1, D_RIGHT = 2, D_HEAT = 3, D_BUZZ = 4;

  function automatic logic [11:0] heat_ceiling(input logic [1:0] lvl);
    case (lvl)
      2'd1:    heat_ceiling = 12'd1800;
      2'd2:    heat_ceiling = 12'd2400;
      2'd3:    heat_ceiling = 12'd3000;
      default: heat_ceiling = 12'd0;
    endcase
  endfunction

endpackage

// ===== hdl/dcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dcc_cfg_regs: setpoint and timing register file
// ----------------------------------------------------------------------------
module dcc_cfg_regs import dcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [11:0] cfg_wdata_i,
  output cfg_t        cfg_o
);
  cfg_t cfg_q;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_low     <= 7'd40;
      cfg_q.temp_med     <= 7'd70;
      cfg_q.temp_high    <= 7'd90;
      cfg_q.heat_low     <= 12'd600;
      cfg_q.heat_med     <= 12'd1200;
      cfg_q.heat_high    <= 12'd1800;
      cfg_q.cool_start   <= 10'd300;
      cfg_q.limit_reload <= 5'd30;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TEMP_LOW:  cfg_q.temp_low     <= cfg_wdata_i[6:0];
        REG_TEMP_MED:  cfg_q.temp_med     <= cfg_wdata_i[6:0];
        REG_TEMP_HIGH: cfg_q.temp_high    <= cfg_wdata_i[6:0];
        REG_HEAT_LOW:  cfg_q.heat_low     <= cfg_wdata_i;
        REG_HEAT_MED:  cfg_q.heat_med     <= cfg_wdata_i;
        REG_HEAT_HIGH: cfg_q.heat_high    <= cfg_wdata_i;
        REG_COOL:      cfg_q.cool_start   <= cfg_wdata_i[9:0];
        REG_LIMIT:     cfg_q.limit_reload <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/dcc_next_state.sv =====
// ----------------------------------------------------------------------------
// dcc_next_state: per-scan sequencer step
// ----------------------------------------------------------------------------
module dcc_next_state import dcc_pkg::*; (
  input  st_t          st_i,
  input  scan_t        scan_i,
  input  cfg_t         cfg_i,
  output st_t          st_o,
  output logic         refresh_o
);
  always_comb begin
    st_t  s;
    logic req_start, req_stop, rf;
    logic signed [8:0] sp;
    logic signed [10:0] t;
    s = st_i;
    req_start = 1'b0;
    req_stop  = 1'b0;
    rf        = 1'b0;
    t = scan_i.temp;

    // one-second tick
    if (scan_i.tick && s.running) begin
      if (s.heat != 12'd0) s.heat = s.heat - 12'd1;
      else if (s.cool != 10'd0) s.cool = s.cool - 10'd1;
      else if (s.phase == PH_DONE && s.beep != 5'd0) s.beep = s.beep - 5'd1;
      if (s.heat == 12'd0 && !s.cooling) s.cooling = 1'b1;
      else if (s.cool == 10'd0 && s.cooling) begin
        s.phase = PH_DONE; s.level = 2'd0; s.page = PG_DONE;
      end
      if (s.pause != 2'd0) s.pause = s.pause - 2'd1;
      else if (s.left != 5'd0) begin s.left = s.left - 5'd1; s.went_left = 1'b1; end
      else if (s.right != 5'd0) begin s.right = s.right - 5'd1; s.went_left = 1'b0; end
      else if (scan_i.one_way) begin s.pause = 2'd0; s.left = 5'd30; end
      else begin
        s.pause = 2'd3;
        if (s.went_left) s.right = 5'd30;
        else s.left = 5'd30;
      end
      if (scan_i.limit_open && !s.cooling) begin
        if (s.limit != 5'd0) s.limit = s.limit - 5'd1;
      end else begin
        s.limit = cfg_i.limit_reload; s.f_limit = 1'b0;
      end
      s.pending = 1'b1;
      rf = 1'b1;
    end
    if (scan_i.door_edge) s.f_door = 1'b1;

    // keys
    if (!s.f_door && !s.f_coil && !s.f_limit) begin
      if (s.phase == PH_RUN) begin
        case (scan_i.key)
          KEY_LOW: begin
            rf = 1'b1;
            if (!s.cooling && s.heat > 12'd60) s.heat = s.heat - 12'd60;
            else if (s.cooling && s.cool > 10'd60) s.cool = s.cool - 10'd60;
          end
          KEY_MED: begin
            rf = 1'b1; s.phase = PH_IDLE; s.level = 2'd0; s.page = PG_INIT;
            req_stop = 1'b1; s.drive = 5'd0;
          end
          KEY_HIGH: begin
            rf = 1'b1;
            if (!s.cooling) begin
              if (s.heat < heat_ceiling(s.level)) s.heat = s.heat + 12'd60;
            end else if (s.cool < 10'd900) s.cool = s.cool + 10'd60;
          end
          KEY_FUNC: begin
            rf = 1'b1; s.heat = 12'd0; s.cooling = 1'b1;
          end
          default: ;
        endcase
      end else if (s.phase == PH_IDLE) begin
        if (scan_i.key inside {KEY_LOW, KEY_MED, KEY_HIGH}) begin
          s.phase = PH_RUN;
          s.level = scan_i.key[1:0];
          case (scan_i.key)
            KEY_LOW: begin s.heat = cfg_i.heat_low;  s.setpoint = cfg_i.temp_low;  end
            KEY_MED: begin s.heat = cfg_i.heat_med;  s.setpoint = cfg_i.temp_med;  end
            default: begin s.heat = cfg_i.heat_high; s.setpoint = cfg_i.temp_high; end
          endcase
          s.cool = cfg_i.cool_start; s.beep = 5'd30; s.cooling = 1'b0;
          s.left = 5'd30; s.right = 5'd0; s.pause = 2'd0;
          req_start = 1'b1; s.page = scan_i.key + 3'd1; rf = 1'b1; s.pending = 1'b1;
        end
      end else if (s.phase == PH_DONE && scan_i.key == KEY_MED) begin
        rf = 1'b1; s.phase = PH_IDLE; s.level = 2'd0; s.page = PG_INIT;
        req_stop = 1'b1; s.drive = 5'd0;
      end
    end

    // door
    if (scan_i.door_edge) begin
      if (scan_i.door_level) begin
        if (s.phase == PH_DONE) begin s.beep = 5'd0; s.level = 2'd0; end
        s.f_door = 1'b1; req_stop = 1'b1; s.page = PG_DOOR; s.phase = PH_STOP;
        s.drive = 5'd0;
      end else begin
        if (!s.f_limit) begin
          if (s.level == 2'd0) begin s.page = PG_INIT; s.phase = PH_IDLE; end
          else begin s.page = {1'b0, s.level} + 3'd1; s.phase = PH_RUN; req_start = 1'b1; end
        end else s.page = PG_LIMIT;
        s.f_door = 1'b0;
      end
      rf = 1'b1;
    end

    // coil
    if (!s.f_door && !s.f_limit && s.phase != PH_DONE) begin
      if (scan_i.coil_broken) begin
        s.f_coil = 1'b1; req_stop = 1'b1; s.page = PG_COIL; rf = 1'b1;
        s.phase = PH_STOP; s.drive = 5'd0;
      end else begin
        s.f_coil = 1'b0;
        if (s.phase == PH_STOP) begin
          if (s.level == 2'd0) begin s.page = PG_INIT; s.phase = PH_IDLE; end
          else begin s.page = {1'b0, s.level} + 3'd1; s.phase = PH_RUN; req_start = 1'b1; end
          rf = 1'b1;
        end
      end
    end

    // limit switch
    if (!s.f_door && !s.f_coil && !s.f_limit) begin
      if (s.phase == PH_RUN && s.limit == 5'd0) begin
        s.f_limit = 1'b1; rf = 1'b1; req_stop = 1'b1; s.phase = PH_STOP;
        s.level = 2'd0; s.page = PG_LIMIT; s.drive = 5'd0;
      end
    end else if (!s.f_door && !s.f_coil && scan_i.key == KEY_MED) begin
      s.phase = PH_IDLE; s.page = PG_INIT; s.limit = cfg_i.limit_reload;
      rf = 1'b1; s.f_limit = 1'b0;
    end

    // drives
    sp = $signed({2'b00, s.setpoint});
    if (!s.f_door && !s.f_coil && !s.f_limit && s.pending) begin
      if (s.phase == PH_RUN) begin
        s.drive[D_FAN] = 1'b1;
        if (s.pause != 2'd0) begin s.drive[D_LEFT] = 1'b0; s.drive[D_RIGHT] = 1'b0; end
        else if (s.left != 5'd0) begin s.drive[D_LEFT] = 1'b1; s.drive[D_RIGHT] = 1'b0; end
        else if (s.right != 5'd0) begin s.drive[D_RIGHT] = 1'b1; s.drive[D_LEFT] = 1'b0; end
        if (!s.cooling && !scan_i.limit_open) begin
          if (t <= 11'sd0 || t > 11'(sp + 9'sd2)) s.drive[D_HEAT] = 1'b0;
          else if (t < 11'(sp - 9'sd5)) s.drive[D_HEAT] = 1'b1;
        end else s.drive[D_HEAT] = 1'b0;
      end else if (s.phase == PH_DONE) begin
        if (s.beep == 5'd0) begin
          s.drive[D_BUZZ] = 1'b0; s.page = PG_INIT; rf = 1'b1; req_stop = 1'b1;
          s.phase = PH_IDLE; s.level = 2'd0;
        end else s.drive[D_BUZZ] = ~s.drive[D_BUZZ];
        s.drive = s.drive & 5'b10000;
      end else s.drive = 5'd0;
      s.pending = 1'b0;
    end

    if (req_start && s.phase == PH_RUN) s.running = 1'b1;
    else if (req_stop) s.running = 1'b0;

    st_o = s;
    refresh_o = rf;
  end
endmodule

// ===== hdl/dryer_cycle_controller.sv =====
// ----------------------------------------------------------------------------
// dryer_cycle_controller: clothes-dryer sequencer, when not stalled one scan request per cycle
// ----------------------------------------------------------------------------
//  channel   | dir | handshake              | payload
//  s_axis    | in  | s_axis_tvalid/tready   | scan request, 24-bit tdata
//  m_axis    | out | m_axis_tvalid/tready   | result request, 32-bit tdata
//  cfg       | in  | cfg_we_i               | cfg_addr_i, cfg_wdata_i
//
// for each scan request the next-state logic reads the state
// registers and the scan, and the new state and result are registered together.
// a new request is taken every cycle while the result register is empty or
// being drained; a stalled output holds the result and blocks input only then.
// reset puts the controller idle with drives off and registers at defaults.
// ----------------------------------------------------------------------------
module dryer_cycle_controller import dcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // tick, key_code[3:1], door_level, door_edge, coil_broken, limit_open,
  // rotate_one_way, temperature[19:9], zero pad[23:20]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // fan_on, drum_left_on, drum_right_on, heater_on, buzzer_on, page_code[7:5],
  // phase_state[9:8], heat_left[21:10], cool_left[31:22]; refresh in tuser
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tuser,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_addr_i,
  input  logic [11:0]      cfg_wdata_i
);
  cfg_t  cfg;
  scan_t scan;
  st_t   st_q, st_d;
  logic  refresh;
  logic  take;
  logic             vld_q;
  logic [OUT_W-1:0] dat_q;
  logic             usr_q;

  dcc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i, .cfg_o(cfg)
  );

  // unpack scan request
  assign scan.tick        = s_axis_tdata[0];
  assign scan.key         = s_axis_tdata[3:1];
  assign scan.door_level  = s_axis_tdata[4];
  assign scan.door_edge   = s_axis_tdata[5];
  assign scan.coil_broken = s_axis_tdata[6];
  assign scan.limit_open  = s_axis_tdata[7];
  assign scan.one_way     = s_axis_tdata[8];
  assign scan.temp        = $signed(s_axis_tdata[19:9]);

  dcc_next_state u_ns (
    .st_i(st_q), .scan_i(scan), .cfg_i(cfg), .st_o(st_d), .refresh_o(refresh)
  );

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= ST_RESET;
      vld_q          <= 1'b0;
    end else begin
      if (take) st_q <= st_d;
      if (take) vld_q <= 1'b1;
      else if (m_axis_tready) vld_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      dat_q <= {st_d.cool, st_d.heat, st_d.phase, st_d.page,
                st_d.drive[D_BUZZ], st_d.drive[D_HEAT], st_d.drive[D_RIGHT],
                st_d.drive[D_LEFT], st_d.drive[D_FAN]};
      usr_q <= refresh;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = dat_q;
  assign m_axis_tuser  = usr_q;
endmodule

// ===== tb/dcc_scoreboard.sv =====
// ----------------------------------------------------------------------------
// dcc_scoreboard: scan-to-result predictor and checker for the dryer controller
// ----------------------------------------------------------------------------
// follows every accepted scan request through its own copy of the sequencer
// state and compares each result request, field by field, with the oldest
// prediction. register writes are mirrored as they happen.
// ----------------------------------------------------------------------------
module dcc_scoreboard import dcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [IN_W-1:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [11:0] cfg_wdata_i,
  output int          outstanding_o,
  output int          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       refresh;
    logic [9:0] cool;
    logic [11:0] heat;
    logic [1:0] phase;
    logic [2:0] page;
    logic       buzz;
    logic       heater;
    logic       right;
    logic       left;
    logic       fan;
  } result_t;

  result_t     result_q[$];
  logic [11:0] cfg_r[8];

  phase_e      ph;
  logic [1:0]  lvl;
  logic        cooling;
  logic [11:0] heat;
  logic [9:0]  cool;
  logic [4:0]  beep;
  logic [6:0]  sp;
  logic [1:0]  pause;
  logic [4:0]  left, right;
  logic        went;
  logic [4:0]  lim;
  logic        fd, fc, fl, running, pending;
  logic [4:0]  drv;
  logic [2:0]  page;
  logic        req_start, req_stop, refr;

  assign outstanding_o = result_q.size();

  task automatic mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors_o++;
  endtask

  function automatic logic [11:0] level_ceiling(logic [1:0] l);
    case (l)
      2'd1:    return 12'd1800;
      2'd2:    return 12'd2400;
      2'd3:    return 12'd3000;
      default: return 12'd0;
    endcase
  endfunction

  task go_idle();
    refr = 1; ph = PH_IDLE; lvl = 0; page = PG_INIT; req_stop = 1; drv = '0;
  endtask

  task resume_level();
    if (lvl == 0) begin
      page = PG_INIT; ph = PH_IDLE;
    end else begin
      page = {1'b0, lvl} + 3'd1; ph = PH_RUN; req_start = 1;
    end
  endtask

  task predict_scan(input logic [IN_W-1:0] d, output result_t r);
    logic [2:0] key;
    logic       lo, ow;
    int         t, s;
    key = d[3:1];
    lo  = d[7];
    ow  = d[8];
    t   = $signed(d[19:9]);
    req_start = 0; req_stop = 0; refr = 0;

    // one-second tick, only while the timer runs
    if (d[0] && running) begin
      if (heat > 0) heat--;
      else if (cool > 0) cool--;
      else if (ph == PH_DONE && beep > 0) beep--;
      if (heat == 0 && !cooling) cooling = 1;
      else if (cool == 0 && cooling) begin
        ph = PH_DONE; lvl = 0; page = PG_DONE;
      end
      if (pause > 0) pause--;
      else if (left > 0) begin left--; went = 1; end
      else if (right > 0) begin right--; went = 0; end
      else if (ow) begin pause = 0; left = 30; end
      else begin
        pause = 3;
        if (went) right = 30;
        else left = 30;
      end
      if (lo && !cooling) begin
        if (lim > 0) lim--;
      end else begin
        lim = cfg_r[REG_LIMIT][4:0]; fl = 0;
      end
      pending = 1; refr = 1;
    end
    if (d[5]) fd = 1;

    if (!fd && !fc && !fl) begin
      if (ph == PH_RUN) begin
        case (key)
          KEY_LOW: begin
            refr = 1;
            if (!cooling && heat > 60) heat -= 60;
            else if (cooling && cool > 60) cool -= 60;
          end
          KEY_MED: go_idle();
          KEY_HIGH: begin
            refr = 1;
            if (!cooling) begin
              if (heat < level_ceiling(lvl)) heat += 60;
            end else if (cool < 900) cool += 60;
          end
          KEY_FUNC: begin
            refr = 1; heat = 0; cooling = 1;
          end
          default: ;
        endcase
      end else if (ph == PH_IDLE) begin
        if (key inside {KEY_LOW, KEY_MED, KEY_HIGH}) begin
          ph = PH_RUN; lvl = key[1:0];
          heat = cfg_r[REG_HEAT_LOW + key - 1];
          cool = cfg_r[REG_COOL][9:0];
          beep = 30;
          sp = cfg_r[REG_TEMP_LOW + key - 1][6:0];
          cooling = 0; left = 30; right = 0; pause = 0;
          req_start = 1; page = key + 3'd1; refr = 1; pending = 1;
        end
      end else if (ph == PH_DONE && key == KEY_MED) go_idle();
    end

    // door interlock
    if (d[5]) begin
      if (d[4]) begin
        if (ph == PH_DONE) begin beep = 0; lvl = 0; end
        fd = 1; req_stop = 1; page = PG_DOOR; ph = PH_STOP; drv = '0;
      end else begin
        if (!fl) resume_level();
        else page = PG_LIMIT;
        fd = 0;
      end
      refr = 1;
    end

    // heater coil check
    if (!fd && !fl && ph != PH_DONE) begin
      if (d[6]) begin
        fc = 1; req_stop = 1; page = PG_COIL; refr = 1; ph = PH_STOP; drv = '0;
      end else begin
        fc = 0;
        if (ph == PH_STOP) begin resume_level(); refr = 1; end
      end
    end

    // limit switch timeout, cleared by the medium key
    if (!fd && !fc && !fl) begin
      if (ph == PH_RUN && lim == 0) begin
        fl = 1; refr = 1; req_stop = 1; ph = PH_STOP; lvl = 0;
        page = PG_LIMIT; drv = '0;
      end
    end else if (!fd && !fc && key == KEY_MED) begin
      ph = PH_IDLE; page = PG_INIT; lim = cfg_r[REG_LIMIT][4:0]; refr = 1; fl = 0;
    end

    // drive update
    if (!fd && !fc && !fl && pending) begin
      if (ph == PH_RUN) begin
        s = sp;
        drv[D_FAN] = 1;
        if (pause > 0) begin drv[D_LEFT] = 0; drv[D_RIGHT] = 0; end
        else if (left > 0) begin drv[D_LEFT] = 1; drv[D_RIGHT] = 0; end
        else if (right > 0) begin drv[D_RIGHT] = 1; drv[D_LEFT] = 0; end
        if (!cooling && !lo) begin
          if (t <= 0 || t > s + 2) drv[D_HEAT] = 0;
          else if (t < s - 5) drv[D_HEAT] = 1;
        end else drv[D_HEAT] = 0;
      end else if (ph == PH_DONE) begin
        if (beep == 0) begin
          drv[D_BUZZ] = 0; page = PG_INIT; refr = 1; req_stop = 1;
          ph = PH_IDLE; lvl = 0;
        end else drv[D_BUZZ] = !drv[D_BUZZ];
        drv = drv & 5'b10000;
      end else drv = '0;
      pending = 0;
    end

    if (req_start && ph == PH_RUN) running = 1;
    else if (req_stop) running = 0;

    r = '{refresh: refr, cool: cool, heat: heat, phase: ph, page: page,
          buzz: drv[D_BUZZ], heater: drv[D_HEAT], right: drv[D_RIGHT],
          left: drv[D_LEFT], fan: drv[D_FAN]};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want, got;
    if (!rst_ni) begin
      result_q.delete();
      errors_o = 0;
      cfg_r = '{12'd40, 12'd70, 12'd90, 12'd600, 12'd1200, 12'd1800, 12'd300, 12'd30};
      ph = PH_IDLE; lvl = 0; cooling = 0; heat = 0; cool = 0; beep = 0; sp = 0;
      pause = 0; left = 30; right = 0; went = 0; lim = 30;
      fd = 0; fc = 0; fl = 0; running = 0; pending = 0; drv = '0; page = PG_INIT;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (result_q.size() == 0) begin
          $display("unexpected result request at %0t", $realtime);
          errors_o++;
        end else begin
          want = result_q.pop_front();
          if (got.fan != want.fan) mismatch("fan_on", got.fan, want.fan);
          if (got.left != want.left) mismatch("drum_left_on", got.left, want.left);
          if (got.right != want.right) mismatch("drum_right_on", got.right, want.right);
          if (got.heater != want.heater) mismatch("heater_on", got.heater, want.heater);
          if (got.buzz != want.buzz) mismatch("buzzer_on", got.buzz, want.buzz);
          if (got.page != want.page) mismatch("page_code", got.page, want.page);
          if (got.phase != want.phase) mismatch("phase_state", got.phase, want.phase);
          if (got.heat != want.heat) mismatch("heat_left", got.heat, want.heat);
          if (got.cool != want.cool) mismatch("cool_left", got.cool, want.cool);
          if (got.refresh != want.refresh) mismatch("refresh", got.refresh, want.refresh);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_scan(s_axis_tdata, want);
        result_q.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_TEMP_LOW, REG_TEMP_MED, REG_TEMP_HIGH: cfg_r[cfg_addr_i] = cfg_wdata_i & 12'h07f;
          REG_COOL:  cfg_r[cfg_addr_i] = cfg_wdata_i & 12'h3ff;
          REG_LIMIT: cfg_r[cfg_addr_i] = cfg_wdata_i & 12'h01f;
          default:   cfg_r[cfg_addr_i] = cfg_wdata_i;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the dryer cycle controller
// ----------------------------------------------------------------------------
// drives a directed set of scans and then random scans shaped as drying
// cycles, under several register settings and three idle patterns; the
// scoreboard beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import dcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // tick, key_code[3:1], door_level, door_edge, coil_broken, limit_open,
  // rotate_one_way, temperature[19:9], zero pad[23:20]
  logic [IN_W-1:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // fan, left, right, heater, buzzer, page[7:5], phase[9:8], heat[21:10],
  // cool[31:22]
  logic [31:0] m_axis_tdata;
  // refresh
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [11:0] cfg_wdata_i;

  int outstanding;
  int errors;
  int send_idle_pct;   // chance per cycle that the scan source holds off
  int recv_idle_pct;   // chance per cycle that the result sink stalls
  int limit_burst;     // scans left with the limit switch forced open
  int temp_center;     // temperatures cluster around one of the current setpoints

  dryer_cycle_controller uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  dcc_scoreboard checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .outstanding_o(outstanding), .errors_o(errors)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2ms;
    $display("tb failed");
    $finish;
  end

  // result sink: random stalls, changed on the falling edge
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [IN_W-1:0] scan(bit tk, logic [2:0] key, bit dl, bit de,
                                           bit coil, bit lo, bit ow, int temp);
    logic [10:0] t;
    t = 11'(temp);
    return {4'b0000, t, ow, lo, coil, de, dl, key, tk};
  endfunction

  // one scan request; returns on the falling edge after acceptance
  task send(input logic [IN_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // stop the source and wait for every outstanding result
  task drain();
    s_axis_tvalid <= 0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task write_settings(input logic [11:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1;
      cfg_addr_i  <= 3'(i);
      cfg_wdata_i <= v[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 0;
    @(negedge clk_i);
    temp_center = v[REG_TEMP_LOW + $urandom_range(2)];
  endtask

  // random scan, mostly a clean running cycle with occasional faults
  function automatic logic [IN_W-1:0] random_scan();
    logic [2:0] key;
    int         temp, r;
    bit         de, lo;
    r = $urandom_range(99);
    if (r < 82) key = KEY_NONE;
    else if (r < 97) key = 3'($urandom_range(KEY_LOW, KEY_FUNC));
    else key = 3'($urandom_range(5, 7));
    r = $urandom_range(99);
    if (r < 60) temp = temp_center + $urandom_range(0, 16) - 10;
    else if (r < 70) temp = -1;
    else if (r < 75) temp = 0;
    else temp = $urandom_range(1023);
    if (temp < -1) temp = -1;
    if (limit_burst > 0) limit_burst--;
    else if ($urandom_range(99) < 2) limit_burst = $urandom_range(10, 45);
    lo = (limit_burst > 0) || ($urandom_range(99) < 8);
    de = ($urandom_range(99) < 3);
    return scan($urandom_range(99) < 75, key, $urandom_range(1) != 0, de,
                $urandom_range(99) < 2, lo, $urandom_range(99) < 20, temp);
  endfunction

  initial begin
    logic [11:0] settings[8];
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    cfg_we_i      = 0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    send_idle_pct = 8;
    recv_idle_pct = 45;
    limit_burst   = 0;
    temp_center   = 40;
    rst_ni        = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: short times so a whole cycle fits in a few scans
    settings = '{12'd40, 12'd70, 12'd127, 12'd3, 12'd2, 12'd3060, 12'd2, 12'd2};
    write_settings(settings);
    send(scan(1, KEY_NONE, 0, 0, 0, 0, 0, 20));      // tick while stopped
    send(scan(0, 3'd5, 0, 0, 0, 0, 0, 20));          // unused key codes
    send(scan(0, 3'd7, 0, 0, 0, 0, 0, 20));
    send(scan(0, KEY_LOW, 0, 0, 0, 0, 0, 20));       // start low level
    send(scan(1, KEY_NONE, 0, 0, 0, 0, 0, -1));      // sensor fault reads off
    send(scan(1, KEY_HIGH, 0, 0, 0, 0, 1, 1023));    // trim up, no reversing
    send(scan(1, KEY_LOW, 0, 0, 0, 0, 0, 0));        // trim down key, no effect with 60 left
    send(scan(0, KEY_NONE, 1, 1, 0, 0, 0, 38));      // door opens
    send(scan(1, KEY_NONE, 1, 0, 0, 0, 0, 38));
    send(scan(0, KEY_NONE, 0, 1, 0, 0, 0, 38));      // door closes, resume
    send(scan(1, KEY_NONE, 0, 0, 1, 0, 0, 38));      // open coil
    send(scan(1, KEY_NONE, 0, 0, 0, 0, 0, 41));      // coil back
    send(scan(1, KEY_FUNC, 0, 0, 0, 0, 0, 30));      // skip to cooling
    send(scan(1, KEY_HIGH, 0, 0, 0, 0, 0, 30));      // cooling trim up
    for (int i = 0; i < 4; i++) send(scan(1, KEY_NONE, 0, 0, 0, 0, 0, 30));
    send(scan(0, KEY_MED, 0, 0, 0, 0, 0, 30));       // stop the cycle while still cooling
    send(scan(0, KEY_NONE, 0, 1, 0, 0, 0, 30));      // spurious edge, no level
    send(scan(0, KEY_HIGH, 0, 0, 0, 0, 0, 127));     // high level; the scans below open the limit
    for (int i = 0; i < 3; i++) send(scan(1, KEY_NONE, 0, 0, 0, 1, 0, 90));
    send(scan(0, KEY_MED, 0, 0, 0, 1, 0, 90));       // clear the limit fault
    drain();  // the source waits here for every result

    // random: six settings across three idle patterns
    for (int chunk = 0; chunk < 6; chunk++) begin
      case (chunk / 2)
        0: begin send_idle_pct = 8;  recv_idle_pct = 45; end
        1: begin send_idle_pct = 45; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      drain();
      case (chunk)
        0: settings = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd1};
        3: settings = '{12'd127, 12'd127, 12'd127, 12'd3060, 12'd3060, 12'd3060,
                        12'd960, 12'd31};
        default: begin
          for (int i = 0; i < 3; i++) settings[i] = $urandom_range(127);
          for (int i = 3; i < 6; i++) settings[i] = $urandom_range(40);
          settings[REG_COOL]  = $urandom_range(30);
          settings[REG_LIMIT] = $urandom_range(1, 31);
        end
      endcase
      write_settings(settings);
      for (int i = 0; i < 290; i++) send(random_scan());
    end

    s_axis_tvalid <= 0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
